/* src/ipsv_pkg.sv */
// Shared constants and types for the inverse Park / space-vector PWM block.
// No dependencies; imported by every module under src.
`timescale 1ns / 1ps

package ipsv_pkg;

  localparam int DATA_W   = 16;  // Q6.10 voltages and duty counts
  localparam int TRIG_W   = 12;  // Q2.10 cosine / sine
  localparam int PERIOD_W = 14;
  localparam int GAIN_W   = 11;
  localparam int CFG_W    = 14;  // widest register
  localparam int ADDR_W   = 2;
  localparam int TIME_W   = 20;  // scaled sector time before 16-bit wrap

  // Register indexes on the configuration port
  localparam logic [ADDR_W-1:0] REG_PERIOD = 2'd0;
  localparam logic [ADDR_W-1:0] REG_GAIN   = 2'd1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 14'd1023;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 11'd94;

  // sqrt(3)/2 in Q2.10
  localparam logic signed [11:0] SQRT3_HALF = 12'sd886;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [TIME_W-1:0] stime_t;

  // Sector numbers (start angle / 60 degrees)
  typedef enum logic [2:0] {
    SEC0 = 3'd0,
    SEC1 = 3'd1,
    SEC2 = 3'd2,
    SEC3 = 3'd3,
    SEC4 = 3'd4,
    SEC5 = 3'd5
  } sector_t;

endpackage

/* src/inverse_park_space_vector_pwm.sv */
// Top level: inverse Park transform followed by centered space-vector PWM.
// Depends on ipsv_pkg, ipsv_park and ipsv_scale.
`timescale 1ns / 1ps

// Channel   Direction  Signals                                  Transfer when
// -------   ---------  ---------------------------------------  ----------------
// input     in         start, busy; volt_d, volt_q,              start && !busy
//                      cos_theta, sin_theta
// result    out        done; volt_alpha, volt_beta, duty_a,      done (one cycle)
//                      duty_b, duty_c, sector_index
// config    in         cfg_wr_en, cfg_addr, cfg_wdata            cfg_wr_en
//
// Fully pipelined: one vector per cycle. The stage count comes from the
// multiplier chain (Park products, sqrt3/2 product, gain, period), each
// product with its own register stage.
// busy is high only during reset; otherwise the pipeline never stalls and the
// receiver cannot hold results off. Reset clears the valid bits and loads the
// register defaults (period 1023, gain 94).
// Registers are sampled mid-pipeline, so write them only while no vector is
// in flight.

module inverse_park_space_vector_pwm import ipsv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  sample_t                  volt_d,
  input  sample_t                  volt_q,
  input  logic signed [TRIG_W-1:0] cos_theta,
  input  logic signed [TRIG_W-1:0] sin_theta,
  output logic                     done,
  output sample_t                  volt_alpha,
  output sample_t                  volt_beta,
  output sample_t                  duty_a,
  output sample_t                  duty_b,
  output sample_t                  duty_c,
  output logic [2:0]               sector_index,
  input  logic                     cfg_wr_en,
  input  logic [ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  localparam int STAGES = 11;

  // ---------------- configuration registers ----------------
  logic [PERIOD_W-1:0] pwm_period;
  logic [GAIN_W-1:0]   voltage_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period   <= PERIOD_RESET;
      voltage_gain <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_PERIOD: pwm_period   <= cfg_wdata[PERIOD_W-1:0];
        REG_GAIN:   voltage_gain <= cfg_wdata[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  // ---------------- valid bits, one per stage ----------------
  logic [STAGES-1:0] vld;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], start & ~busy};
    end
  end

  assign done = vld[STAGES-1];

  // ---------------- stages 1-2: inverse Park ----------------
  sample_t alpha2, beta2;

  ipsv_park u_park (
    .clk        (clk),
    .volt_d     (volt_d),
    .volt_q     (volt_q),
    .cos_theta  (cos_theta),
    .sin_theta  (sin_theta),
    .volt_alpha (alpha2),
    .volt_beta  (beta2)
  );

  // alpha/beta ride along to the output: index 0 is stage 3, index 8 is stage 11
  sample_t alpha_dly [9];
  sample_t beta_dly  [9];

  always_ff @(posedge clk) begin
    alpha_dly[0] <= alpha2;
    beta_dly[0]  <= beta2;
    for (int i = 1; i < 9; i++) begin
      alpha_dly[i] <= alpha_dly[i-1];
      beta_dly[i]  <= beta_dly[i-1];
    end
  end

  // ---------------- stage 3: sqrt3/2 * alpha, beta/2 ----------------
  logic signed [27:0] prod886;
  sample_t            half3;
  sample_t            beta_rnd;

  // add one to negatives so the shift truncates toward zero
  assign beta_rnd = beta2 + $signed({15'd0, beta2[15]});

  always_ff @(posedge clk) begin
    prod886 <= SQRT3_HALF * alpha2;
    half3   <= beta_rnd >>> 1;
  end

  // ---------------- stage 4: rotated phase references ----------------
  sample_t m3;
  sample_t r1, r2, r3;

  assign m3 = prod886[25:10];

  always_ff @(posedge clk) begin
    r1 <= beta_dly[0];
    r2 <= m3 - half3;
    r3 <= -half3 - m3;
  end

  // ---------------- stage 5: sector and sector times ----------------
  sample_t a_next, b_next, a5, b5;
  sector_t sec_next;
  sector_t sec_dly [7];  // index 0 is stage 5, index 6 is stage 11

  always_comb begin
    if (!r1[15]) begin
      if (!r2[15]) begin
        a_next = r2;  b_next = r1;  sec_next = SEC0;
      end else if (!r3[15]) begin
        a_next = r1;  b_next = r3;  sec_next = SEC2;
      end else begin
        a_next = -r2; b_next = -r3; sec_next = SEC1;
      end
    end else begin
      if (!r2[15]) begin
        if (!r3[15]) begin
          a_next = r3;  b_next = r2;  sec_next = SEC4;
        end else begin
          a_next = -r3; b_next = -r1; sec_next = SEC5;
        end
      end else begin
        a_next = -r1; b_next = -r2; sec_next = SEC3;
      end
    end
  end

  always_ff @(posedge clk) begin
    a5         <= a_next;
    b5         <= b_next;
    sec_dly[0] <= sec_next;
    for (int i = 1; i < 7; i++) begin
      sec_dly[i] <= sec_dly[i-1];
    end
  end

  // ---------------- stages 6-8: scale both times ----------------
  stime_t t1_8, t2_8;

  ipsv_scale u_scale_t1 (
    .clk          (clk),
    .time_in      (a5),
    .voltage_gain (voltage_gain),
    .pwm_period   (pwm_period),
    .time_out     (t1_8)
  );

  ipsv_scale u_scale_t2 (
    .clk          (clk),
    .time_in      (b5),
    .voltage_gain (voltage_gain),
    .pwm_period   (pwm_period),
    .time_out     (t2_8)
  );

  // ---------------- stage 9: ts = (period - t1 - t2) / 2 ----------------
  logic signed [21:0] diff;
  logic [21:0]        diff_rnd;
  sample_t            ts9, t1_9, t2_9;

  assign diff     = 22'($signed({1'b0, pwm_period})) - 22'(t1_8) - 22'(t2_8);
  assign diff_rnd = diff + 22'(diff[21]);

  always_ff @(posedge clk) begin
    ts9  <= diff_rnd[16:1];
    t1_9 <= t1_8[15:0];
    t2_9 <= t2_8[15:0];
  end

  // ---------------- stage 10: tm ----------------
  sample_t ts10, tm10, t2_10;

  always_ff @(posedge clk) begin
    ts10  <= ts9;
    tm10  <= ts9 + t1_9;
    t2_10 <= t2_9;
  end

  // ---------------- stage 11: tl, sector permutation, outputs ----------------
  sample_t tl10;
  sample_t da, db, dc;

  assign tl10 = tm10 + t2_10;

  always_ff @(posedge clk) begin
    case (sec_dly[5])
      SEC0:    begin da <= ts10; db <= tm10; dc <= tl10; end
      SEC1:    begin da <= tm10; db <= ts10; dc <= tl10; end
      SEC2:    begin da <= tl10; db <= ts10; dc <= tm10; end
      SEC3:    begin da <= tl10; db <= tm10; dc <= ts10; end
      SEC4:    begin da <= tm10; db <= tl10; dc <= ts10; end
      default: begin da <= ts10; db <= tl10; dc <= tm10; end
    endcase
  end

  assign volt_alpha   = alpha_dly[8];
  assign volt_beta    = beta_dly[8];
  assign duty_a       = da;
  assign duty_b       = db;
  assign duty_c       = dc;
  assign sector_index = sec_dly[6];

  // ---------------- assertions ----------------
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, STAGES))
    else $error("result without a matching input transfer");

  a_alpha_align: assert property (@(posedge clk) disable iff (rst)
    done |-> volt_alpha == $past(alpha2, 9))
    else $error("alpha delay line out of step");

  a_sector_align: assert property (@(posedge clk) disable iff (rst)
    done |-> sector_index == $past(sec_next, 7))
    else $error("sector delay line out of step");

endmodule

/* src/ipsv_park.sv */
// Inverse Park rotation, two register stages: products, then sum/difference.
// Depends on ipsv_pkg.
`timescale 1ns / 1ps

module ipsv_park import ipsv_pkg::*; (
  input  logic                     clk,
  input  sample_t                  volt_d,
  input  sample_t                  volt_q,
  input  logic signed [TRIG_W-1:0] cos_theta,
  input  logic signed [TRIG_W-1:0] sin_theta,
  output sample_t                  volt_alpha,
  output sample_t                  volt_beta
);

  logic signed [DATA_W+TRIG_W-1:0] prod_dc;
  logic signed [DATA_W+TRIG_W-1:0] prod_qs;
  logic signed [DATA_W+TRIG_W-1:0] prod_ds;
  logic signed [DATA_W+TRIG_W-1:0] prod_qc;

  always_ff @(posedge clk) begin
    prod_dc <= volt_d * cos_theta;
    prod_qs <= volt_q * sin_theta;
    prod_ds <= volt_d * sin_theta;
    prod_qc <= volt_q * cos_theta;
  end

  // Q6.10 floor shift, wrap to 16 bits
  always_ff @(posedge clk) begin
    volt_alpha <= prod_dc[25:10] - prod_qs[25:10];
    volt_beta  <= prod_ds[25:10] + prod_qc[25:10];
  end

endmodule

/* src/ipsv_scale.sv */
// Sector time scaling: gain (unsigned Q1.10), times period, divide by 1024 toward zero.
// Three register stages. Depends on ipsv_pkg.
`timescale 1ns / 1ps

module ipsv_scale import ipsv_pkg::*; (
  input  logic                clk,
  input  sample_t             time_in,
  input  logic [GAIN_W-1:0]   voltage_gain,
  input  logic [PERIOD_W-1:0] pwm_period,
  output stime_t              time_out
);

  logic signed [DATA_W+GAIN_W:0]   prod_gain;
  logic signed [DATA_W+PERIOD_W:0] prod_period;
  logic signed [DATA_W+PERIOD_W:0] biased;
  sample_t                         gained;

  assign gained = prod_gain[25:10];
  // add 1023 to negative values so the shift truncates toward zero
  assign biased = prod_period +
                  $signed({{(DATA_W+PERIOD_W-9){1'b0}}, {10{prod_period[DATA_W+PERIOD_W]}}});

  always_ff @(posedge clk) begin
    prod_gain   <= time_in * $signed({1'b0, voltage_gain});
    prod_period <= gained * $signed({1'b0, pwm_period});
    time_out    <= biased[TIME_W+9:10];
  end

endmodule
